// ----- hw/rtl/http_header_length_scanner_assert.svh -----
// ----------------------------------------------------------------------------
// HTTP header length scanner assertion macros
// Concurrent assertion shorthands, clocked on clk and off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LENGTH_SCANNER_ASSERT_SVH
`define HTTP_HEADER_LENGTH_SCANNER_ASSERT_SVH

// expr must never hold
`define HHLS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

// cons must hold in the same cycle as ante
`define HHLS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define HHLS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/hhls_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP header length scanner package
// Widths, character codes, status codes and the byte class record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hhls_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int VALUE_BITS   = 32;
  localparam int PROD_BITS    = VALUE_BITS + 4;
  localparam int CFG_BITS     = 17;
  localparam int BYTE_BITS    = 8;
  localparam int DIGIT_BITS   = 4;
  localparam int KEY_LEN      = 15;
  localparam int KEY_POS_BITS = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = 2;

  // buffer size 8192 after reset, so the scan stops after 8191 bytes
  localparam logic [COUNT_BITS-1:0] RESET_LIMIT = COUNT_BITS'(8191);
  localparam logic [CFG_BITS-1:0]   CFG_MIN     = CFG_BITS'(2);

  localparam logic [BYTE_BITS-1:0] CHAR_CR  = 8'h0D;
  localparam logic [BYTE_BITS-1:0] CHAR_LF  = 8'h0A;
  localparam logic [BYTE_BITS-1:0] CHAR_SP  = 8'h20;
  localparam logic [BYTE_BITS-1:0] CHAR_TAB = 8'h09;
  localparam logic [BYTE_BITS-1:0] CHAR_0   = 8'h30;
  localparam logic [BYTE_BITS-1:0] CHAR_9   = 8'h39;
  localparam logic [BYTE_BITS-1:0] CHAR_UA  = 8'h41;
  localparam logic [BYTE_BITS-1:0] CHAR_UZ  = 8'h5A;
  localparam logic [BYTE_BITS-1:0] CASE_GAP = 8'h20;

  // key in lower case; first character sits in the top byte
  localparam logic [BYTE_BITS*KEY_LEN-1:0] KEY_TEXT = "content-length:";

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_ABSENT    = 2'd1,
    ST_MALFORMED = 2'd2
  } length_status_t;

  typedef struct packed {
    logic                  eos;
    logic                  is_cr;
    logic                  is_lf;
    logic                  is_blank;
    logic                  is_digit;
    logic [DIGIT_BITS-1:0] digit;
    logic [KEY_LEN-1:0]    key_hit;
  } byte_class_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

// ----- hw/rtl/hhls_channels.sv -----
// ----------------------------------------------------------------------------
// HTTP header length scanner channels
// Valid/ready interfaces for the byte input, the result output and the
// buffer size write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hhls_in_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [hhls_pkg::BYTE_BITS-1:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface hhls_out_if;
  logic                            valid;
  logic                            ready;
  logic [hhls_pkg::COUNT_BITS-1:0] header_bytes;
  logic                            terminated;
  logic [1:0]                      length_status;
  logic [hhls_pkg::VALUE_BITS-1:0] content_length;
  logic                            length_overflow;

  modport source (output valid, header_bytes, terminated, length_status,
                  content_length, length_overflow, input ready);
  modport sink   (input valid, header_bytes, terminated, length_status,
                  content_length, length_overflow, output ready);
endinterface

interface hhls_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hhls_pkg::CFG_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/http_header_length_scanner.sv -----
// ----------------------------------------------------------------------------
// HTTP header length scanner
// Path: a byte transfer goes into the queue, is popped by the back end, and a
//   scan end registers the result onto out_ch; input stalls once four bytes
//   wait behind a held result. Throughput: one byte per cycle unless a held
//   result waits, with a combinational multiply-by-ten add per queued byte.
// Reset: synchronous on rst_n low; buffer size 8192, queue empty, no result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_header_length_scanner_assert.svh"

module http_header_length_scanner (
  input  logic        clk,
  input  logic        rst_n,
  hhls_in_if.sink     in_ch,
  hhls_cfg_if.sink    cfg_ch,
  hhls_out_if.source  out_ch
);

  hhls_pkg::byte_class_t push_data;
  hhls_pkg::byte_class_t pop_data;
  hhls_pkg::queue_stat_t q_stat;
  logic                  q_push;
  logic                  q_pop;

  hhls_front u_front (
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (push_data)
  );

  hhls_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  hhls_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_data (pop_data),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  `HHLS_ASSERT_NEVER(a_queue_full_and_empty, q_stat.full && q_stat.empty, "queue full and empty")
  `HHLS_ASSERT_NEXT(a_xfer_queued, in_ch.valid && in_ch.ready, !q_stat.empty, "byte lost")
  `HHLS_ASSERT_NOW(a_result_from_pop, $rose(out_ch.valid), $past(q_pop), "result without a pop")

endmodule

// ----- hw/rtl/hhls_front.sv -----
// ----------------------------------------------------------------------------
// HTTP header length scanner front end
// Accepts input transfers and classifies each byte for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhls_front (
  hhls_in_if.sink               in_ch,
  input  hhls_pkg::queue_stat_t q_stat,
  output logic                  q_push,
  output hhls_pkg::byte_class_t q_data
);

  logic [hhls_pkg::BYTE_BITS-1:0] b;
  logic [hhls_pkg::BYTE_BITS-1:0] folded;
  logic [hhls_pkg::BYTE_BITS-1:0] digit_full;

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;

  assign b          = in_ch.data_byte;
  assign folded     = (b >= hhls_pkg::CHAR_UA && b <= hhls_pkg::CHAR_UZ) ?
                      b + hhls_pkg::CASE_GAP : b;
  assign digit_full = b - hhls_pkg::CHAR_0;

  always_comb begin
    q_data.eos      = in_ch.kind;
    q_data.is_cr    = (b == hhls_pkg::CHAR_CR);
    q_data.is_lf    = (b == hhls_pkg::CHAR_LF);
    q_data.is_blank = (b == hhls_pkg::CHAR_SP) || (b == hhls_pkg::CHAR_TAB);
    q_data.is_digit = (b >= hhls_pkg::CHAR_0) && (b <= hhls_pkg::CHAR_9);
    q_data.digit    = digit_full[hhls_pkg::DIGIT_BITS-1:0];
    // compare against every key position at once
    for (int i = 0; i < hhls_pkg::KEY_LEN; i++) begin
      q_data.key_hit[i] = (folded == hhls_pkg::KEY_TEXT[
        hhls_pkg::BYTE_BITS*(hhls_pkg::KEY_LEN-1-i) +: hhls_pkg::BYTE_BITS]);
    end
  end

endmodule

// ----- hw/rtl/hhls_queue.sv -----
// ----------------------------------------------------------------------------
// HTTP header length scanner queue
// Short FIFO of classified bytes between front end and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhls_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  hhls_pkg::byte_class_t push_data,
  input  logic                  pop,
  output hhls_pkg::byte_class_t pop_data,
  output hhls_pkg::queue_stat_t stat
);

  hhls_pkg::byte_class_t           slot_r [hhls_pkg::QUEUE_DEPTH];
  logic [hhls_pkg::QUEUE_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [hhls_pkg::QUEUE_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [hhls_pkg::QUEUE_AW:0]     count_r, count_nxt;

  assign stat.full  = (count_r == (hhls_pkg::QUEUE_AW+1)'(hhls_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/hhls_back.sv -----
// ----------------------------------------------------------------------------
// HTTP header length scanner back end
// Runs the line, key, digit and terminator tracking on classified bytes
// and holds the result in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhls_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hhls_pkg::byte_class_t q_data,
  input  hhls_pkg::queue_stat_t q_stat,
  output logic                  q_pop,
  hhls_cfg_if.sink              cfg_ch,
  hhls_out_if.source            out_ch
);

  typedef enum logic [5:0] {
    LP_KEY        = 6'b000001,
    LP_OTHER      = 6'b000010,
    LP_AT_KEY_END = 6'b000100,
    LP_BLANK      = 6'b001000,
    LP_DIGITS     = 6'b010000,
    LP_DONE       = 6'b100000
  } line_phase_t;

  typedef enum logic [3:0] {
    TP_IDLE     = 4'b0001,
    TP_CR       = 4'b0010,
    TP_CRLF     = 4'b0100,
    TP_CRLFCR   = 4'b1000
  } term_phase_t;

  line_phase_t                          lp_r, lp_nxt;
  term_phase_t                          tp_r, tp_nxt;
  logic [hhls_pkg::COUNT_BITS-1:0]      count_r, count_nxt;
  logic [hhls_pkg::KEY_POS_BITS-1:0]    kpos_r, kpos_nxt;
  logic                                 prev_cr_r, prev_cr_nxt;
  logic [hhls_pkg::VALUE_BITS-1:0]      pval_r, pval_nxt;
  logic                                 pdig_r, pdig_nxt;
  logic                                 povf_r, povf_nxt;
  hhls_pkg::length_status_t             dstat_r, dstat_nxt;
  logic [hhls_pkg::VALUE_BITS-1:0]      dval_r, dval_nxt;
  logic                                 dovf_r, dovf_nxt;
  logic [hhls_pkg::COUNT_BITS-1:0]      limit_r, limit_nxt;

  logic                                 out_valid_r, out_valid_nxt;
  logic [hhls_pkg::COUNT_BITS-1:0]      out_bytes_r;
  logic                                 out_term_r;
  hhls_pkg::length_status_t             out_stat_r;
  logic [hhls_pkg::VALUE_BITS-1:0]      out_val_r;
  logic                                 out_ovf_r;

  logic [hhls_pkg::COUNT_BITS-1:0]      cnt_inc;
  logic [hhls_pkg::PROD_BITS-1:0]       ext;
  logic [hhls_pkg::PROD_BITS-1:0]       sum;
  logic                                 add_ovf;
  logic [hhls_pkg::VALUE_BITS-1:0]      add_val;
  logic [hhls_pkg::CFG_BITS-1:0]        cfg_dec;
  logic                                 emit;
  logic                                 term;
  logic                                 eol;
  logic                                 take_digit;
  hhls_pkg::length_status_t             res_stat;
  logic [hhls_pkg::VALUE_BITS-1:0]      res_val;
  logic                                 res_ovf;

  assign cfg_ch.ready = 1'b1;
  assign q_pop        = !q_stat.empty && (!out_valid_r || out_ch.ready);
  assign cnt_inc      = count_r + 1'b1;

  // value * 10 + digit, saturate once the top bits are touched
  assign ext     = {4'b0000, pval_r};
  assign sum     = (ext << 3) + (ext << 1) + hhls_pkg::PROD_BITS'(q_data.digit);
  assign add_ovf = povf_r || (sum[hhls_pkg::PROD_BITS-1:hhls_pkg::VALUE_BITS] != '0);
  assign add_val = add_ovf ? '1 : sum[hhls_pkg::VALUE_BITS-1:0];

  // scan limit is buffer size minus one, at least 1 and clamped to the count range
  assign cfg_dec = cfg_ch.data - 1'b1;
  always_comb begin
    limit_nxt = limit_r;
    if (cfg_ch.valid) begin
      priority if (cfg_ch.data < hhls_pkg::CFG_MIN) begin
        limit_nxt = hhls_pkg::COUNT_BITS'(1);
      end else if (cfg_dec[hhls_pkg::CFG_BITS-1:hhls_pkg::COUNT_BITS] != '0) begin
        limit_nxt = '1;
      end else begin
        limit_nxt = cfg_dec[hhls_pkg::COUNT_BITS-1:0];
      end
    end
  end

  always_comb begin
    lp_nxt      = lp_r;
    tp_nxt      = tp_r;
    count_nxt   = count_r;
    kpos_nxt    = kpos_r;
    prev_cr_nxt = prev_cr_r;
    pval_nxt    = pval_r;
    pdig_nxt    = pdig_r;
    povf_nxt    = povf_r;
    dstat_nxt   = dstat_r;
    dval_nxt    = dval_r;
    dovf_nxt    = dovf_r;
    emit        = 1'b0;
    term        = 1'b0;
    eol         = 1'b0;
    take_digit  = 1'b0;

    if (q_pop) begin
      if (q_data.eos) begin
        emit = 1'b1;
      end else begin
        count_nxt = cnt_inc;

        // line content and line end
        priority if (prev_cr_r) begin
          if (q_data.is_lf) begin
            prev_cr_nxt = 1'b0;
            eol         = 1'b1;
          end else begin
            // the held CR is content; it ends any key or value on this line
            unique case (lp_r)
              LP_KEY:                            lp_nxt = LP_OTHER;
              LP_AT_KEY_END, LP_BLANK, LP_DIGITS: lp_nxt = LP_DONE;
              default:                           lp_nxt = lp_r;
            endcase
            prev_cr_nxt = q_data.is_cr;
          end
        end else if (q_data.is_cr) begin
          prev_cr_nxt = 1'b1;
        end else begin
          unique case (lp_r)
            LP_KEY: begin
              if (q_data.key_hit[kpos_r]) begin
                kpos_nxt = kpos_r + 1'b1;
                if (kpos_r == hhls_pkg::KEY_POS_BITS'(hhls_pkg::KEY_LEN - 1)) begin
                  lp_nxt = LP_AT_KEY_END;
                end
              end else begin
                lp_nxt = LP_OTHER;
              end
            end
            LP_AT_KEY_END, LP_BLANK: begin
              priority if (q_data.is_blank) begin
                lp_nxt = LP_BLANK;
              end else if (q_data.is_digit) begin
                take_digit = 1'b1;
                lp_nxt     = LP_DIGITS;
              end else begin
                lp_nxt = LP_DONE;
              end
            end
            LP_DIGITS: begin
              if (q_data.is_digit) begin
                take_digit = 1'b1;
              end else begin
                lp_nxt = LP_DONE;
              end
            end
            default: lp_nxt = lp_r;
          endcase
        end

        if (take_digit) begin
          pdig_nxt = 1'b1;
          povf_nxt = add_ovf;
          pval_nxt = add_val;
        end

        if (eol) begin
          if (dstat_r == hhls_pkg::ST_ABSENT &&
              (lp_r == LP_BLANK || lp_r == LP_DIGITS || lp_r == LP_DONE)) begin
            if (pdig_r) begin
              dstat_nxt = hhls_pkg::ST_FOUND;
              dval_nxt  = pval_r;
              dovf_nxt  = povf_r;
            end else begin
              dstat_nxt = hhls_pkg::ST_MALFORMED;
            end
          end
          lp_nxt   = LP_KEY;
          kpos_nxt = '0;
          pval_nxt = '0;
          pdig_nxt = 1'b0;
          povf_nxt = 1'b0;
        end

        // CR LF CR LF tracking
        unique case (tp_r)
          TP_CR:     tp_nxt = q_data.is_lf ? TP_CRLF : (q_data.is_cr ? TP_CR : TP_IDLE);
          TP_CRLF:   tp_nxt = q_data.is_cr ? TP_CRLFCR : TP_IDLE;
          TP_CRLFCR: begin
            term   = q_data.is_lf;
            tp_nxt = q_data.is_cr ? TP_CR : TP_IDLE;
          end
          default:   tp_nxt = q_data.is_cr ? TP_CR : TP_IDLE;
        endcase

        emit = term || (cnt_inc >= limit_r);
      end
    end

    // decided fields as they stand after this byte, before the scan clear
    res_stat = dstat_nxt;
    res_val  = dval_nxt;
    res_ovf  = dovf_nxt;

    // a result starts the next scan from scratch
    if (emit) begin
      lp_nxt      = LP_KEY;
      tp_nxt      = TP_IDLE;
      count_nxt   = '0;
      kpos_nxt    = '0;
      prev_cr_nxt = 1'b0;
      pval_nxt    = '0;
      pdig_nxt    = 1'b0;
      povf_nxt    = 1'b0;
      dstat_nxt   = hhls_pkg::ST_ABSENT;
      dval_nxt    = '0;
      dovf_nxt    = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r        <= LP_KEY;
      tp_r        <= TP_IDLE;
      count_r     <= '0;
      kpos_r      <= '0;
      prev_cr_r   <= 1'b0;
      pval_r      <= '0;
      pdig_r      <= 1'b0;
      povf_r      <= 1'b0;
      dstat_r     <= hhls_pkg::ST_ABSENT;
      dval_r      <= '0;
      dovf_r      <= 1'b0;
      limit_r     <= hhls_pkg::RESET_LIMIT;
      out_valid_r <= 1'b0;
    end else begin
      lp_r        <= lp_nxt;
      tp_r        <= tp_nxt;
      count_r     <= count_nxt;
      kpos_r      <= kpos_nxt;
      prev_cr_r   <= prev_cr_nxt;
      pval_r      <= pval_nxt;
      pdig_r      <= pdig_nxt;
      povf_r      <= povf_nxt;
      dstat_r     <= dstat_nxt;
      dval_r      <= dval_nxt;
      dovf_r      <= dovf_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the result from the state as it stands after this byte
  always_ff @(posedge clk) begin
    if (emit) begin
      out_bytes_r <= q_data.eos ? count_r : cnt_inc;
      out_term_r  <= term;
      out_stat_r  <= res_stat;
      out_val_r   <= res_val;
      out_ovf_r   <= res_ovf;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.header_bytes    = out_bytes_r;
  assign out_ch.terminated      = out_term_r;
  assign out_ch.length_status   = out_stat_r;
  assign out_ch.content_length  = out_val_r;
  assign out_ch.length_overflow = out_ovf_r;

endmodule
